[hdl/slfd_pkg.sv]
// Shared constants for the sync/length frame deframer.
package slfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;

  localparam logic [ByteW-1:0] SYNC_FIRST  = 8'hFF;
  localparam logic [ByteW-1:0] SYNC_SECOND = 8'h00;

  localparam logic [KindW-1:0] KIND_PAYLOAD    = 3'd0;
  localparam logic [KindW-1:0] KIND_GOOD       = 3'd1;
  localparam logic [KindW-1:0] KIND_CSUM_ERR   = 3'd2;
  localparam logic [KindW-1:0] KIND_BAD_SYNC   = 3'd3;
  localparam logic [KindW-1:0] KIND_BAD_SECOND = 3'd4;

endpackage

[hdl/sync_length_frame_deframer_top.sv]
// Top level of the sync/length frame deframer.
//
// Takes one received byte per cycle while input ready is high and parses
// frames of the form 0xFF, 0x00, length, command, length-1 payload bytes,
// checksum (sum mod 256 of length, command and payload). Each payload
// byte yields one result word, the checksum byte yields frame-good or
// checksum-error, and a bad first or second sync byte yields a header
// error; sync, length and command bytes yield nothing. The result of an
// accepted byte appears in the output register in the next cycle; input
// ready falls only while the output holds a word downstream has not taken.
module sync_length_frame_deframer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [slfd_pkg::ByteW-1:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [slfd_pkg::ByteW-1:0]  m_axis_tdata    // [2:0] kind, [7:3] zero
);
  import slfd_pkg::*;

  localparam logic [2:0] PH_SYNC     = 3'd0;
  localparam logic [2:0] PH_SECOND   = 3'd1;
  localparam logic [2:0] PH_LENGTH   = 3'd2;
  localparam logic [2:0] PH_COMMAND  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD  = 3'd4;
  localparam logic [2:0] PH_CHECKSUM = 3'd5;

  logic [2:0]       phase_q, phase_d;
  logic [ByteW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] exp_len_q, exp_len_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic             out_valid_q, out_valid_d;
  logic [KindW-1:0] out_kind_q, out_kind_d;
  logic             res_valid;
  logic [KindW-1:0] res_kind;
  logic [ByteW-1:0] pos_inc;
  logic             accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pos_inc       = pos_q + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    exp_len_d = exp_len_q;
    sum_d     = sum_q;
    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    unique case (phase_q)
      PH_SECOND: begin
        if (s_axis_tdata == SYNC_SECOND) begin
          phase_d = PH_LENGTH;
        end else begin
          phase_d   = PH_SYNC;
          pos_d     = '0;
          res_valid = 1'b1;
          res_kind  = KIND_BAD_SECOND;
        end
      end
      PH_LENGTH: begin
        exp_len_d = (s_axis_tdata == '0) ? '0 : s_axis_tdata - 8'd1;
        pos_d     = '0;
        sum_d     = sum_q + s_axis_tdata;
        phase_d   = PH_COMMAND;
      end
      PH_COMMAND: begin
        sum_d   = sum_q + s_axis_tdata;
        phase_d = (exp_len_q == '0) ? PH_CHECKSUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_d     = sum_q + s_axis_tdata;
        pos_d     = pos_inc;
        res_valid = 1'b1;
        res_kind  = KIND_PAYLOAD;
        if (pos_inc == exp_len_q) begin
          phase_d = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        phase_d   = PH_SYNC;
        res_valid = 1'b1;
        res_kind  = (s_axis_tdata == sum_q) ? KIND_GOOD : KIND_CSUM_ERR;
      end
      default: begin
        if (s_axis_tdata == SYNC_FIRST) begin
          sum_d     = '0;
          exp_len_d = '0;
          phase_d   = PH_SECOND;
        end else begin
          phase_d   = PH_SYNC;
          res_valid = 1'b1;
          res_kind  = KIND_BAD_SYNC;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
      out_kind_d  = res_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC;
      pos_q       <= '0;
      exp_len_q   <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        exp_len_q <= exp_len_d;
        sum_q     <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ByteW-KindW){1'b0}}, out_kind_q};

endmodule

[hdl/slfd_checker.sv]
// Port-level checker for the sync/length frame deframer, with its bind.
module slfd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [slfd_pkg::ByteW-1:0] m_axis_tdata
);
  import slfd_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ByteW-1:KindW] == '0 &&
      m_axis_tdata[KindW-1:0] <= KIND_BAD_SECOND)
    else $error("illegal result kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result word without an accepted input word");

endmodule

bind sync_length_frame_deframer_top slfd_checker u_slfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/tb_sync_length_frame_deframer_top.sv]
// Frame deframer testbench: directed rows with set kinds, random bytes checked by a parser model.
module tb_sync_length_frame_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slfd_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC, PH_SECOND, PH_LENGTH, PH_COMMAND, PH_PAYLOAD, PH_CHECKSUM
  } parse_phase_e;

  typedef struct {
    parse_phase_e     phase;
    logic [ByteW-1:0] count;
    logic [ByteW-1:0] body_len;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] command;
  } parser_t;

  typedef enum logic [1:0] {ROW_MODEL, ROW_SILENT, ROW_KIND} row_check_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    row_check_e       check;
    logic [KindW-1:0] kind;
  } stim_row_t;

  localparam int unsigned RandomBytes   = 1150;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldAt        = 200;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DirectedRows  = 23;

  localparam stim_row_t DIRECTED [DirectedRows] = '{
    '{8'h00, ROW_KIND,   KIND_BAD_SYNC},
    '{8'h7F, ROW_KIND,   KIND_BAD_SYNC},
    '{8'hFF, ROW_SILENT, KIND_PAYLOAD},
    '{8'h01, ROW_KIND,   KIND_BAD_SECOND},
    '{8'hFF, ROW_SILENT, KIND_PAYLOAD},
    '{8'hFF, ROW_KIND,   KIND_BAD_SECOND},
    '{8'hFF, ROW_SILENT, KIND_PAYLOAD},
    '{8'h00, ROW_SILENT, KIND_PAYLOAD},
    '{8'h00, ROW_SILENT, KIND_PAYLOAD},
    '{8'hAA, ROW_SILENT, KIND_PAYLOAD},
    '{8'hAA, ROW_KIND,   KIND_GOOD},
    '{8'hFF, ROW_SILENT, KIND_PAYLOAD},
    '{8'h00, ROW_SILENT, KIND_PAYLOAD},
    '{8'h01, ROW_SILENT, KIND_PAYLOAD},
    '{8'h55, ROW_SILENT, KIND_PAYLOAD},
    '{8'h00, ROW_KIND,   KIND_CSUM_ERR},
    '{8'hFF, ROW_MODEL,  KIND_PAYLOAD},
    '{8'h00, ROW_MODEL,  KIND_PAYLOAD},
    '{8'h03, ROW_MODEL,  KIND_PAYLOAD},
    '{8'hFF, ROW_MODEL,  KIND_PAYLOAD},
    '{8'h80, ROW_KIND,   KIND_PAYLOAD},
    '{8'h7F, ROW_MODEL,  KIND_PAYLOAD},
    '{8'h01, ROW_MODEL,  KIND_PAYLOAD}
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [ByteW-1:0] m_axis_tdata;

  parser_t          parser;
  logic [KindW-1:0] kind_q [$];
  int unsigned      bytes_sent, words_seen, errors, stall_cycles;
  int unsigned      n_payload, n_good, n_csum, n_header;
  bit               idle_tx = 1'b1;
  bit               idle_rx = 1'b1;

  sync_length_frame_deframer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit parse_byte(input logic [ByteW-1:0] b, output logic [KindW-1:0] kind);
    kind = KIND_PAYLOAD;
    case (parser.phase)
      PH_SECOND: begin
        if (b == SYNC_SECOND) begin
          parser.phase = PH_LENGTH;
          return 1'b0;
        end
        parser.phase = PH_SYNC;
        parser.count = '0;
        kind = KIND_BAD_SECOND;
        return 1'b1;
      end
      PH_LENGTH: begin
        parser.body_len = (b == 8'd0) ? 8'd0 : b - 8'd1;
        parser.count = '0;
        parser.sum = parser.sum + b;
        parser.phase = PH_COMMAND;
        return 1'b0;
      end
      PH_COMMAND: begin
        parser.command = b;
        parser.sum = parser.sum + b;
        parser.phase = (parser.body_len == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        parser.sum = parser.sum + b;
        parser.count = parser.count + 8'd1;
        if (parser.count == parser.body_len) parser.phase = PH_CHECKSUM;
        return 1'b1;
      end
      PH_CHECKSUM: begin
        parser.phase = PH_SYNC;
        kind = (b == parser.sum) ? KIND_GOOD : KIND_CSUM_ERR;
        return 1'b1;
      end
      default: begin
        if (b == SYNC_FIRST) begin
          parser.sum = '0;
          parser.body_len = '0;
          parser.phase = PH_SECOND;
          return 1'b0;
        end
        parser.phase = PH_SYNC;
        kind = KIND_BAD_SYNC;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input row_check_e check = ROW_MODEL,
                           input logic [KindW-1:0] typed = KIND_PAYLOAD);
    int unsigned      gap;
    logic [KindW-1:0] kind;
    bit               has_word;
    gap = idle_tx ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    has_word = parse_byte(b, kind);
    case (check)
      ROW_MODEL: begin
        if (has_word) kind_q.push_back(kind);
      end
      ROW_KIND: begin
        kind_q.push_back(typed);
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int unsigned      pick, len, rand_start;
    logic [ByteW-1:0] sum, cmd, pb;
    parser = '{PH_SYNC, '0, '0, '0, '0};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < DirectedRows; i++) begin
      send_byte(DIRECTED[i].data, DIRECTED[i].check, DIRECTED[i].kind);
    end
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RandomBytes) begin
      if ($urandom_range(0, 7) == 0) idle_tx = !idle_tx;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_byte(ByteW'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        send_byte(SYNC_FIRST);
        send_byte(ByteW'($urandom_range(1, 255)));
      end else begin
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
        cmd = ByteW'($urandom_range(0, 255));
        sum = len[ByteW-1:0] + cmd;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(len[ByteW-1:0]);
        send_byte(cmd);
        for (int i = 1; i < len; i++) begin
          pb = ByteW'($urandom_range(0, 255));
          sum = sum + pb;
          send_byte(pb);
        end
        send_byte(($urandom_range(0, 3) == 0) ? ByteW'($urandom_range(0, 255)) : sum);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (kind_q.size() == 0);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes, checked %0d result words with idle and stall gaps and a long hold-off",
             bytes_sent, words_seen);
    $display("Words: %0d payload, %0d good frames, %0d checksum errors, %0d header errors",
             n_payload, n_good, n_csum, n_header);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned      gap;
    bit               held;
    logic [KindW-1:0] want;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && words_seen == HoldAt) begin
        held = 1'b1;
        gap = HoldCycles;
      end else begin
        gap = idle_rx ? $urandom_range(0, 9) : 0;
      end
      if ($urandom_range(0, 49) == 0) idle_rx = !idle_rx;
      @(negedge clk_i);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      words_seen++;
      if (kind_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got 0x%02h", $time, m_axis_tdata);
      end else begin
        want = kind_q.pop_front();
        if (m_axis_tdata[KindW-1:0] !== want) begin
          errors++;
          $display("%0t: kind mismatch, expected %0d, got %0d", $time, want,
                   m_axis_tdata[KindW-1:0]);
        end
        if (m_axis_tdata[ByteW-1:KindW] !== '0) begin
          errors++;
          $display("%0t: padding mismatch, expected 0, got 0x%02h", $time,
                   m_axis_tdata[ByteW-1:KindW]);
        end
        case (want)
          KIND_PAYLOAD:  n_payload++;
          KIND_GOOD:     n_good++;
          KIND_CSUM_ERR: n_csum++;
          default:       n_header++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d words still expected", $time,
               stall_cycles, kind_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
